FILE: design/psce_pkg.sv
// ----------------------------------------------------------------------------
// psce_pkg
// Shared types and constants for the piecewise cubic spline evaluator.
// ----------------------------------------------------------------------------
package psce_pkg;

  localparam int MAX_BREAKPOINTS = 256;
  localparam int BP_AW           = $clog2(MAX_BREAKPOINTS);
  localparam int COEF_DEPTH      = (MAX_BREAKPOINTS - 1) * 4;
  localparam int COEF_AW         = $clog2(COEF_DEPTH);
  localparam int CNT_W           = 9;

  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_BREAKPOINTS);

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [95:0] RND_HALF = 96'h8000;

  localparam logic [2:0] REG_BREAKPOINTS_IN_USE = 3'd0;

  typedef enum logic [1:0] {
    CMD_WR_BP   = 2'd0,
    CMD_WR_COEF = 2'd1,
    CMD_EVAL_VAL = 2'd2,
    CMD_EVAL_DER = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         table_index;
    logic [1:0]         coefficient_slot;
    logic signed [31:0] position;
    logic signed [63:0] coefficient_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               out_of_range;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_CMP,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic first;
    logic last;
    logic cmp;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic acc;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic oor;
    logic more_init;
    logic more_cmp;
    logic last_stage;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/psce_ctrl.sv
// ----------------------------------------------------------------------------
// psce_ctrl
// Sequencer: bounds check, segment search steps, Horner stages, result load.
// ----------------------------------------------------------------------------
module psce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  psce_pkg::cmd_t      in_cmd,
  input  psce_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output psce_pkg::ctl_cmd_t  cmd
);

  psce_pkg::state_t state_r;
  psce_pkg::state_t state_nxt;
  logic             accept;
  logic             is_eval;

  assign in_ready = (state_r == psce_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_eval  = in_cmd inside {psce_pkg::CMD_EVAL_VAL, psce_pkg::CMD_EVAL_DER};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psce_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psce_pkg::S_IDLE: begin
        if (accept && is_eval) state_nxt = psce_pkg::S_FIRST;
      end
      psce_pkg::S_FIRST: state_nxt = psce_pkg::S_LAST;
      psce_pkg::S_LAST: begin
        if (stat.oor)            state_nxt = psce_pkg::S_DONE;
        else if (stat.more_init) state_nxt = psce_pkg::S_CMP;
        else                     state_nxt = psce_pkg::S_MUL_LO;
      end
      psce_pkg::S_CMP: begin
        if (!stat.more_cmp) state_nxt = psce_pkg::S_MUL_LO;
      end
      psce_pkg::S_MUL_LO: state_nxt = psce_pkg::S_MUL_HI;
      psce_pkg::S_MUL_HI: state_nxt = psce_pkg::S_ADD;
      psce_pkg::S_ADD:    state_nxt = psce_pkg::S_ACC;
      psce_pkg::S_ACC: begin
        state_nxt = stat.last_stage ? psce_pkg::S_DONE : psce_pkg::S_MUL_LO;
      end
      psce_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = psce_pkg::S_IDLE;
      end
      default: state_nxt = psce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      psce_pkg::S_IDLE:   cmd.accept   = accept;
      psce_pkg::S_FIRST:  cmd.first    = 1'b1;
      psce_pkg::S_LAST:   cmd.last     = 1'b1;
      psce_pkg::S_CMP:    cmd.cmp      = 1'b1;
      psce_pkg::S_MUL_LO: cmd.mul_lo   = 1'b1;
      psce_pkg::S_MUL_HI: cmd.mul_hi   = 1'b1;
      psce_pkg::S_ADD:    cmd.add      = 1'b1;
      psce_pkg::S_ACC:    cmd.acc      = 1'b1;
      psce_pkg::S_DONE:   cmd.out_load = stat.out_free;
      default:            cmd          = '0;
    endcase
  end

endmodule

FILE: design/psce_datapath.sv
// ----------------------------------------------------------------------------
// psce_datapath
// Breakpoint and coefficient memories, search registers, shared 32x32
// multiplier with Horner accumulator, and the result register.
// ----------------------------------------------------------------------------
module psce_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psce_pkg::ctl_cmd_t              cmd,
  input  psce_pkg::in_item_t              in_item,
  input  logic [psce_pkg::CNT_W-1:0]      n_cfg,
  input  logic                            out_ready,
  output psce_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  output psce_pkg::out_item_t             out_item
);

  logic [31:0] bp_mem   [psce_pkg::MAX_BREAKPOINTS];
  logic [63:0] coef_mem [psce_pkg::COEF_DEPTH];

  logic signed [31:0]          bp_rdata_r;
  logic signed [63:0]          coef_rdata_r;
  logic [psce_pkg::BP_AW-1:0]  bp_addr;
  logic [psce_pkg::COEF_AW-1:0] coef_addr;
  logic [psce_pkg::COEF_AW-1:0] coef_waddr;

  logic signed [31:0]          x_r;
  logic                        deriv_r;
  logic                        low_fail_r;
  logic                        oor_r;
  logic [psce_pkg::BP_AW-1:0]  lo_r, hi_r, mid_r;
  logic [psce_pkg::BP_AW-1:0]  lo_nxt, hi_nxt, mid_nxt, init_mid;
  logic [psce_pkg::BP_AW:0]    mid_sum;
  logic [psce_pkg::CNT_W-1:0]  n_m1, n_m2, n_half;
  logic                        oor_c;

  logic [1:0]                  stage_r;
  logic [1:0]                  slot;
  logic [1:0]                  k;
  logic signed [32:0]          mul_a;
  logic signed [64:0]          mul_p;
  logic signed [64:0]          p_lo_r, p_lo_nxt;
  logic signed [63:0]          p_hi_r, p_hi_nxt;
  logic [95:0]                 prod_r, prod_nxt;
  logic [65:0]                 c_ext, kc_r, kc_nxt;
  logic [80:0]                 sum;
  logic                        fits;
  logic [63:0]                 acc_r, acc_nxt;
  logic                        clip_r;
  logic                        out_valid_r;
  psce_pkg::out_item_t         out_item_r;

  assign n_m1   = n_cfg - psce_pkg::CNT_W'(1);
  assign n_m2   = n_cfg - psce_pkg::CNT_W'(2);
  assign n_half = n_m1 >> 1;
  assign init_mid = n_half[psce_pkg::BP_AW-1:0];

  always_comb begin
    if ($signed(x_r) >= $signed(bp_rdata_r)) begin
      lo_nxt = mid_r;
      hi_nxt = hi_r;
    end else begin
      lo_nxt = lo_r;
      hi_nxt = mid_r - psce_pkg::BP_AW'(1);
    end
    mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt} + (psce_pkg::BP_AW+1)'(1);
    mid_nxt = mid_sum[psce_pkg::BP_AW:1];
  end

  always_comb begin
    bp_addr = '0;
    if (cmd.first)     bp_addr = n_m1[psce_pkg::BP_AW-1:0];
    else if (cmd.last) bp_addr = init_mid;
    else if (cmd.cmp)  bp_addr = mid_nxt;
  end

  assign oor_c = low_fail_r || (x_r > bp_rdata_r);

  assign slot       = 2'd3 - stage_r;
  assign k          = deriv_r ? (2'd3 - stage_r) : 2'd1;
  assign coef_addr  = {lo_r, slot};
  assign coef_waddr = {in_item.table_index, in_item.coefficient_slot};

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_item.cmd == psce_pkg::CMD_WR_BP)) begin
      bp_mem[in_item.table_index] <= in_item.position;
    end
    bp_rdata_r <= bp_mem[bp_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_item.cmd == psce_pkg::CMD_WR_COEF) &&
        ({1'b0, in_item.table_index} < psce_pkg::CNT_W'(psce_pkg::MAX_BREAKPOINTS - 1))) begin
      coef_mem[coef_waddr] <= in_item.coefficient_value;
    end
    if (cmd.mul_lo) begin
      coef_rdata_r <= coef_mem[coef_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= in_item.position;
      deriv_r <= (in_item.cmd == psce_pkg::CMD_EVAL_DER);
    end
    if (cmd.first) low_fail_r <= (x_r < bp_rdata_r);
    if (cmd.last) begin
      oor_r <= oor_c;
      lo_r  <= '0;
      hi_r  <= n_m2[psce_pkg::BP_AW-1:0];
      mid_r <= init_mid;
    end
    if (cmd.cmp) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  assign mul_a    = cmd.mul_lo ? $signed({1'b0, acc_r[31:0]}) :
                                 $signed({acc_r[63], acc_r[63:32]});
  assign mul_p    = mul_a * x_r;
  assign p_lo_nxt = mul_p;
  assign p_hi_nxt = mul_p[63:0];
  assign prod_nxt = {p_hi_r, 32'd0} + {{31{p_lo_r[64]}}, p_lo_r} + psce_pkg::RND_HALF;
  assign c_ext    = {{2{coef_rdata_r[63]}}, coef_rdata_r};

  always_comb begin
    case (k)
      2'd3:    kc_nxt = c_ext + {c_ext[64:0], 1'b0};
      2'd2:    kc_nxt = {c_ext[64:0], 1'b0};
      default: kc_nxt = c_ext;
    endcase
  end

  assign sum  = {prod_r[95], prod_r[95:16]} + {{15{kc_r[65]}}, kc_r};
  assign fits = (&sum[80:63]) || !(|sum[80:63]);

  always_comb begin
    if (fits)         acc_nxt = sum[63:0];
    else if (sum[80]) acc_nxt = psce_pkg::SAT_MIN;
    else              acc_nxt = psce_pkg::SAT_MAX;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) p_lo_r <= p_lo_nxt;
    if (cmd.mul_hi) p_hi_r <= p_hi_nxt;
    if (cmd.add) begin
      prod_r <= prod_nxt;
      kc_r   <= kc_nxt;
    end
    if (cmd.last) begin
      acc_r   <= '0;
      clip_r  <= 1'b0;
      stage_r <= '0;
    end else if (cmd.acc) begin
      acc_r   <= acc_nxt;
      clip_r  <= clip_r || !fits;
      stage_r <= stage_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.result_value <= oor_r ? 64'sd0 : $signed(acc_r);
      out_item_r.out_of_range <= oor_r;
      out_item_r.saturated    <= !oor_r && clip_r;
    end
  end

  assign stat.oor        = oor_c;
  assign stat.more_init  = (n_cfg > psce_pkg::N_MIN);
  assign stat.more_cmp   = (lo_nxt < hi_nxt);
  assign stat.last_stage = deriv_r ? (stage_r == 2'd2) : (stage_r == 2'd3);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: design/piecewise_cubic_spline_eval.sv
// ----------------------------------------------------------------------------
// piecewise_cubic_spline_eval
// Cubic spline evaluator over non-uniform breakpoints (value or derivative).
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid/in_ready    psce_pkg::in_item_t
//   out_*     output     out_valid/out_ready  psce_pkg::out_item_t
//   APB       input      psel/penable/pready  breakpoints_in_use at 0x0
//
// Table writes never stall the input and may follow back to back.
// An evaluation holds in_ready low: FIRST/LAST check bounds, CMP runs the
// search probes (about log2 of segments, set by the one-read breakpoint
// memory), and each Horner stage (4 value, 3 derivative) runs MUL_LO,
// MUL_HI, ADD, ACC on the shared 32x32 multiplier. Out of range skips to DONE.
// Reset is synchronous; memories hold garbage until written, no clearing pass.
// A stalled result waits in the output register; the block holds in DONE
// until the register frees.
// ----------------------------------------------------------------------------
module piecewise_cubic_spline_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psce_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output psce_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [psce_pkg::CNT_W-1:0] n_r;
  logic [psce_pkg::CNT_W-1:0] n_nxt;
  logic [psce_pkg::CNT_W-1:0] wr_val;
  logic                       cfg_wr;
  psce_pkg::ctl_cmd_t         cmd;
  psce_pkg::dp_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == psce_pkg::REG_BREAKPOINTS_IN_USE);
  assign wr_val = pwdata[psce_pkg::CNT_W-1:0];

  always_comb begin
    if (wr_val < psce_pkg::N_MIN)      n_nxt = psce_pkg::N_MIN;
    else if (wr_val > psce_pkg::N_MAX) n_nxt = psce_pkg::N_MAX;
    else                               n_nxt = wr_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= psce_pkg::N_MIN;
    end else if (cfg_wr) begin
      n_r <= n_nxt;
    end
  end

  assign prdata = (paddr == psce_pkg::REG_BREAKPOINTS_IN_USE) ?
                  {{(32-psce_pkg::CNT_W){1'b0}}, n_r} : 32'd0;

  psce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  psce_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .n_cfg     (n_r),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: design/psce_checker.sv
// ----------------------------------------------------------------------------
// psce_checker
// Port-level checks for the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module psce_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input psce_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input psce_pkg::out_item_t out_item,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_of_range |->
      out_item.result_value == 64'sd0 && !out_item.saturated)
    else $error("out-of-range result not zero or flagged saturated");

  a_write_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_item.cmd == psce_pkg::CMD_WR_BP || in_item.cmd == psce_pkg::CMD_WR_COEF)
      |=> in_ready)
    else $error("table write request stalled the input");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_item.cmd == psce_pkg::CMD_EVAL_VAL || in_item.cmd == psce_pkg::CMD_EVAL_DER)
      |=> !in_ready && !$rose(out_valid))
    else $error("evaluate request did not occupy the block");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind piecewise_cubic_spline_eval psce_checker u_psce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .pready    (pready)
);
